// ===== rtl/core/rccs_pkg.sv =====
// Shared types and constants for the raw channel clip statistics block.
package rccs_pkg;

  // Fixed widths of the record fields
  localparam int NUM_CH       = 4;
  localparam int CH_W         = 2;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 48;
  localparam int COUNT_OUT_W  = 32;
  localparam int CLIP_W       = 17;
  localparam int CFG_INDEX_W  = 4;

  // Parameter defaults
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COUNT_BITS  = 32;

  // Clip level after reset: above every sample, so nothing counts
  localparam logic [CLIP_W-1:0] CLIP_RESET = 17'h10000;

  // CFA channel codes
  localparam logic [CH_W-1:0] CH_RED       = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN     = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE      = 2'd2;
  localparam logic [CH_W-1:0] CH_GREEN_TWO = 2'd3;
  localparam logic [CH_W-1:0] CH_LAST      = CH_GREEN_TWO;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_RED       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_GREEN     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_BLUE      = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_GREEN_TWO = 4'd3;

  // One per-channel statistics record
  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [COUNT_OUT_W-1:0] count;
    logic [SAMPLE_W-1:0]    peak;
    logic [COUNT_OUT_W-1:0] clipped;
  } rec_t;

endpackage

// ===== rtl/core/raw_channel_clip_stats.sv =====
// Top level of the raw channel clip statistics block.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------------
//   in       | in        | in_valid / in_stall  | sample, channel, final_sample
//   out      | out       | out_valid / out_stall| channel_id, sample_sum, sample_count,
//            |           |                      | peak_value, clipped_count, last_record
//   cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle unless stalled: a sample is held in the input register, then its
// accumulator update lands. A final sample loads four records into the record buffer;
// they leave one per cycle while out_stall is low, the first once the buffer is loaded
// from the input register. Samples keep flowing while records drain; the input stalls
// only when a second final sample reaches the update stage before the buffer has sent
// its last record. Reset clears the accumulators, the buffer state and sets all clip
// levels to 65536. cfg_ready is always high.
module raw_channel_clip_stats
  import rccs_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic [CH_W-1:0]        channel,
  input  logic                   final_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CH_W-1:0]        channel_id,
  output logic [SUM_W-1:0]       sample_sum,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic [SAMPLE_W-1:0]    peak_value,
  output logic [COUNT_OUT_W-1:0] clipped_count,
  output logic                   last_record,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CLIP_W-1:0]      cfg_data
);

  logic [CLIP_W-1:0]      clip_level [NUM_CH];
  logic                   stage_valid;
  logic [SAMPLE_BITS-1:0] stage_sample;
  logic [CH_W-1:0]        stage_channel;
  logic                   stage_final;
  logic                   proceed;
  logic                   in_xfer;
  logic                   drain_free;
  rec_t                   snap [NUM_CH];

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CH; k++) begin
        clip_level[k] <= CLIP_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLIP_RED:       clip_level[0] <= cfg_data;
        CFG_CLIP_GREEN:     clip_level[1] <= cfg_data;
        CFG_CLIP_BLUE:      clip_level[2] <= cfg_data;
        CFG_CLIP_GREEN_TWO: clip_level[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage handshake: a final sample waits for a free record buffer
  assign proceed  = stage_valid && (!stage_final || drain_free);
  assign in_stall = stage_valid && !proceed;
  assign in_xfer  = in_valid && !in_stall;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_xfer) begin
      stage_valid <= 1'b1;
    end else if (proceed) begin
      stage_valid <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_sample  <= sample[SAMPLE_BITS-1:0];
      stage_channel <= channel;
      stage_final   <= final_sample;
    end
  end

  rccs_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .upd_valid  (proceed),
    .upd_sample (stage_sample),
    .upd_channel(stage_channel),
    .upd_final  (stage_final),
    .clip_level (clip_level),
    .snap       (snap)
  );

  rccs_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .load         (proceed && stage_final),
    .snap         (snap),
    .free         (drain_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_id   (channel_id),
    .sample_sum   (sample_sum),
    .sample_count (sample_count),
    .peak_value   (peak_value),
    .clipped_count(clipped_count),
    .last_record  (last_record)
  );

  // Input stalls only while records are waiting to leave
  a_stall_needs_records: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no records pending");

  // A run's records restart at red after the last one leaves
  a_run_restarts_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_record |=> !out_valid || channel_id == CH_RED)
    else $error("record sequence did not restart at red");

  // Records appear only after a final sample was processed
  a_records_from_final: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(proceed && stage_final))
    else $error("records appeared without a final sample");

  // Records advance one channel per transfer
  a_channel_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_record |=> out_valid
      && channel_id == $past(channel_id) + CH_W'(1))
    else $error("record channel did not advance by one");

endmodule

// ===== rtl/core/rccs_accum.sv =====
// Per-channel accumulators: saturating sum, count, peak and clip count.
module rccs_accum
  import rccs_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd_valid,
  input  logic [SAMPLE_BITS-1:0] upd_sample,
  input  logic [CH_W-1:0]        upd_channel,
  input  logic                   upd_final,
  input  logic [CLIP_W-1:0]      clip_level [NUM_CH],
  output rec_t                   snap [NUM_CH]
);

  localparam int CNT_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_OUT_W : COUNT_BITS;

  logic [SUM_W-1:0]       sum_acc   [NUM_CH];
  logic [CNT_W-1:0]       count_acc [NUM_CH];
  logic [SAMPLE_BITS-1:0] peak_acc  [NUM_CH];
  logic [CNT_W-1:0]       clip_acc  [NUM_CH];

  logic [SUM_W-1:0]       sum_next   [NUM_CH];
  logic [CNT_W-1:0]       count_next [NUM_CH];
  logic [SAMPLE_BITS-1:0] peak_next  [NUM_CH];
  logic [CNT_W-1:0]       clip_next  [NUM_CH];

  logic [SUM_W:0]  sum_wide [NUM_CH];
  logic            hit      [NUM_CH];
  logic            is_clip  [NUM_CH];

  // Update the addressed channel; others hold
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      hit[k]      = upd_channel == CH_W'(k);
      is_clip[k]  = CLIP_W'(upd_sample) >= clip_level[k];
      sum_wide[k] = (SUM_W+1)'(sum_acc[k]) + (SUM_W+1)'(upd_sample);
      sum_next[k]   = sum_acc[k];
      count_next[k] = count_acc[k];
      peak_next[k]  = peak_acc[k];
      clip_next[k]  = clip_acc[k];
      if (hit[k]) begin
        sum_next[k] = sum_wide[k][SUM_W] ? {SUM_W{1'b1}} : sum_wide[k][SUM_W-1:0];
        if (!(&count_acc[k])) begin
          count_next[k] = count_acc[k] + CNT_W'(1);
        end
        if (upd_sample > peak_acc[k]) begin
          peak_next[k] = upd_sample;
        end
        if (is_clip[k] && !(&clip_acc[k])) begin
          clip_next[k] = clip_acc[k] + CNT_W'(1);
        end
      end
      snap[k].sum     = sum_next[k];
      snap[k].count   = COUNT_OUT_W'(count_next[k]);
      snap[k].peak    = SAMPLE_W'(peak_next[k]);
      snap[k].clipped = COUNT_OUT_W'(clip_next[k]);
    end
  end

  // Advance accumulators; clear after the final sample of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CH; k++) begin
        sum_acc[k]   <= '0;
        count_acc[k] <= '0;
        peak_acc[k]  <= '0;
        clip_acc[k]  <= '0;
      end
    end else if (upd_valid) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (upd_final) begin
          sum_acc[k]   <= '0;
          count_acc[k] <= '0;
          peak_acc[k]  <= '0;
          clip_acc[k]  <= '0;
        end else begin
          sum_acc[k]   <= sum_next[k];
          count_acc[k] <= count_next[k];
          peak_acc[k]  <= peak_next[k];
          clip_acc[k]  <= clip_next[k];
        end
      end
    end
  end

endmodule

// ===== rtl/core/rccs_drain.sv =====
// Record buffer that holds one run's four records and sends them in order.
module rccs_drain
  import rccs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  rec_t                   snap [NUM_CH],
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CH_W-1:0]        channel_id,
  output logic [SUM_W-1:0]       sample_sum,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic [SAMPLE_W-1:0]    peak_value,
  output logic [COUNT_OUT_W-1:0] clipped_count,
  output logic                   last_record
);

  rec_t            rec_buf [NUM_CH];
  logic            busy;
  logic [CH_W-1:0] idx;
  logic            done;

  // Last record leaves this cycle
  assign done = busy && !out_stall && (idx == CH_LAST);
  assign free = !busy || done;

  // Drive the current record
  assign out_valid     = busy;
  assign channel_id    = idx;
  assign sample_sum    = rec_buf[idx].sum;
  assign sample_count  = rec_buf[idx].count;
  assign peak_value    = rec_buf[idx].peak;
  assign clipped_count = rec_buf[idx].clipped;
  assign last_record   = idx == CH_LAST;

  // Load a new run or advance through the records
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= CH_RED;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= CH_RED;
    end else if (busy && !out_stall) begin
      if (idx == CH_LAST) begin
        busy <= 1'b0;
        idx  <= CH_RED;
      end else begin
        idx <= idx + CH_W'(1);
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (load) begin
      rec_buf <= snap;
    end
  end

endmodule
